// ===== hw/rtl/ptlv_pkg.sv =====
// Package with the request, response and control types of the page table block.
`timescale 1ns / 1ps
`default_nettype none

package ptlv_pkg;

  localparam int unsigned PAGES_DFLT  = 64;
  localparam int unsigned FRAMES_DFLT = 16;
  localparam int unsigned STAMP_W     = 32;

  localparam logic [7:0] NO_FRAME       = 8'hFF;
  localparam int unsigned FLAG_VALID_BIT = 0;
  localparam logic [7:0] FLAG_REF       = 8'h20;
  localparam logic [7:0] RIGHTS_MASK    = 8'h1E;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_TOUCH  = 2'd2,
    CMD_VICTIM = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] page_num;
    logic [7:0] frame_in;
    logic [7:0] flags_in;
    logic [7:0] perm_mask;
  } ptlv_req_t;

  typedef struct packed {
    logic       status;
    logic [7:0] frame_out;
    logic [7:0] flags_out;
    logic       permitted;
    logic [3:0] victim;
  } ptlv_rsp_t;

  typedef struct packed {
    logic capture;
    logic access;
    logic exec;
    logic scan;
  } ptlv_ctl_t;

  typedef struct packed {
    cmd_e cmd;
    logic page_ok;
    logic scan_last;
  } ptlv_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/page_table_lru_victim_top.sv =====
// Top level of the page table with least recently used victim selection.
// A write or a rejected request ends in the access step; lookup and touch go on to the
// exec step; a victim request goes on to scan all frames. The done strobe is registered
// after the last step, and a new request is taken only when idle. The victim scan reads
// one frame stamp per cycle from the stamp memory port. The receiver cannot stall results.
// Reset clears all page entries to no frame, all stamps and the access counter at once.
`timescale 1ns / 1ps
`default_nettype none

module page_table_lru_victim_top import ptlv_pkg::*; #(
  parameter int unsigned PAGES  = PAGES_DFLT,
  parameter int unsigned FRAMES = FRAMES_DFLT
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  input  wire ptlv_req_t req_i,
  output logic           done_o,
  output ptlv_rsp_t      rsp_o
);

  ptlv_ctl_t ctl;
  ptlv_sts_t sts;

  ptlv_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .busy_o  (busy),
    .ctl_o   (ctl)
  );

  ptlv_dp #(.PAGES(PAGES), .FRAMES(FRAMES)) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .ctl_i  (ctl),
    .sts_o  (sts),
    .rsp_o  (rsp_o),
    .done_o (done_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/ptlv_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ptlv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ptlv_dp.sv =====
// Datapath: request register, page table and stamp memories, counter and victim scan.
`timescale 1ns / 1ps
`default_nettype none

module ptlv_dp import ptlv_pkg::*; #(
  parameter int unsigned PAGES  = PAGES_DFLT,
  parameter int unsigned FRAMES = FRAMES_DFLT
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ptlv_req_t req_i,
  input  wire ptlv_ctl_t ctl_i,
  output ptlv_sts_t      sts_o,
  output ptlv_rsp_t      rsp_o,
  output logic           done_o
);

  localparam int unsigned PW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned FW = $clog2(FRAMES);
  localparam int unsigned CW = FW + 1;

  ptlv_req_t req_q;
  ptlv_rsp_t rsp_d, rsp_q;
  logic      done_d, done_q;

  logic              page_ok;
  logic [PW-1:0]     page_idx;
  logic              frame_in_ok;

  logic              pt_we;
  logic [15:0]       pt_wdata;
  logic [15:0]       pt_rdata;
  logic [PAGES-1:0]  pt_valid_q;
  logic [7:0]        ent_frame;
  logic [7:0]        ent_flags;
  logic              ent_mapped;
  logic [7:0]        need;

  logic               st_we;
  logic [STAMP_W-1:0] st_rdata;
  logic [FRAMES-1:0]  st_valid_q;
  logic [STAMP_W-1:0] cnt_d, cnt_q;

  logic [CW-1:0]      iss_q;
  logic               issue_ok;
  logic               cmp_v_q;
  logic [FW-1:0]      cmp_idx_q;
  logic               cmp_sv_q;
  logic [STAMP_W-1:0] cmp_val;
  logic               take;
  logic [STAMP_W-1:0] min_d, min_q;
  logic [FW-1:0]      best_d, best_q;
  logic               scan_last;

  assign page_ok     = {1'b0, req_q.page_num} < 9'(PAGES);
  assign page_idx    = req_q.page_num[PW-1:0];
  assign frame_in_ok = req_q.frame_in < 8'(FRAMES);

  ptlv_ram #(.WIDTH(16), .DEPTH(PAGES)) u_pt_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (page_idx),
    .wdata_i (pt_wdata),
    .raddr_i (page_idx),
    .rdata_o (pt_rdata)
  );

  ptlv_ram #(.WIDTH(STAMP_W), .DEPTH(FRAMES)) u_st_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (ent_frame[FW-1:0]),
    .wdata_i (cnt_d),
    .raddr_i (iss_q[FW-1:0]),
    .rdata_o (st_rdata)
  );

  assign ent_frame  = pt_valid_q[page_idx] ? pt_rdata[15:8] : NO_FRAME;
  assign ent_flags  = pt_valid_q[page_idx] ? pt_rdata[7:0] : 8'h00;
  assign ent_mapped = ent_frame < 8'(FRAMES);
  assign need       = req_q.perm_mask & RIGHTS_MASK;

  assign issue_ok  = iss_q < CW'(FRAMES);
  assign cmp_val   = cmp_sv_q ? st_rdata : '0;
  assign take      = cmp_v_q && ((cmp_idx_q == '0) || (cmp_val < min_q));
  assign min_d     = take ? cmp_val : min_q;
  assign best_d    = take ? cmp_idx_q : best_q;
  assign scan_last = cmp_v_q && (cmp_idx_q == FW'(FRAMES - 1));

  always_comb begin
    pt_we    = 1'b0;
    pt_wdata = {req_q.frame_in, req_q.flags_in};
    st_we    = 1'b0;
    cnt_d    = cnt_q;
    rsp_d    = '0;
    done_d   = 1'b0;
    if (ctl_i.access) begin
      case (req_q.cmd)
        CMD_WRITE: begin
          done_d = 1'b1;
          if (!page_ok || (req_q.flags_in[FLAG_VALID_BIT] && !frame_in_ok)) begin
            rsp_d.status = 1'b1;
          end else begin
            pt_we = 1'b1;
          end
        end
        CMD_LOOKUP: begin
          if (!page_ok) begin
            done_d          = 1'b1;
            rsp_d.status    = 1'b1;
            rsp_d.frame_out = NO_FRAME;
          end
        end
        CMD_TOUCH: begin
          if (!page_ok) begin
            done_d       = 1'b1;
            rsp_d.status = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    if (ctl_i.exec) begin
      done_d = 1'b1;
      if (req_q.cmd == CMD_LOOKUP) begin
        rsp_d.frame_out = ent_frame;
        rsp_d.flags_out = ent_flags;
        rsp_d.permitted = ent_flags[FLAG_VALID_BIT] && ((ent_flags & need) == need);
      end else if (ent_mapped) begin
        cnt_d    = cnt_q + 1'b1;
        st_we    = 1'b1;
        pt_we    = 1'b1;
        pt_wdata = {ent_frame, ent_flags | FLAG_REF};
      end
    end
    if (ctl_i.scan && scan_last) begin
      done_d       = 1'b1;
      rsp_d.victim = 4'(best_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      req_q <= req_i;
    end
    rsp_q     <= rsp_d;
    min_q     <= min_d;
    best_q    <= best_d;
    cmp_idx_q <= iss_q[FW-1:0];
    cmp_sv_q  <= st_valid_q[iss_q[FW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q     <= 1'b0;
      pt_valid_q <= '0;
      st_valid_q <= '0;
      cnt_q      <= '0;
      iss_q      <= '0;
      cmp_v_q    <= 1'b0;
    end else begin
      done_q <= done_d;
      cnt_q  <= cnt_d;
      if (pt_we) begin
        pt_valid_q[page_idx] <= 1'b1;
      end
      if (st_we) begin
        st_valid_q[ent_frame[FW-1:0]] <= 1'b1;
      end
      if (ctl_i.access) begin
        iss_q   <= '0;
        cmp_v_q <= 1'b0;
      end else if (ctl_i.scan) begin
        if (issue_ok) begin
          iss_q   <= iss_q + 1'b1;
          cmp_v_q <= 1'b1;
        end else begin
          cmp_v_q <= 1'b0;
        end
      end
    end
  end

  assign sts_o.cmd       = req_q.cmd;
  assign sts_o.page_ok   = page_ok;
  assign sts_o.scan_last = scan_last;
  assign rsp_o           = rsp_q;
  assign done_o          = done_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ptlv_ctrl.sv =====
// Controller state machine that sequences each request through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module ptlv_ctrl import ptlv_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire ptlv_sts_t sts_i,
  output logic           busy_o,
  output ptlv_ctl_t      ctl_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ACCESS = 4'b0010,
    ST_EXEC   = 4'b0100,
    ST_SCAN   = 4'b1000
  } state_e;

  state_e state_d, state_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        case (sts_i.cmd)
          CMD_LOOKUP, CMD_TOUCH: state_d = sts_i.page_ok ? ST_EXEC : ST_IDLE;
          CMD_VICTIM:            state_d = ST_SCAN;
          default:               state_d = ST_IDLE;
        endcase
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (sts_i.scan_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign ctl_o.capture = (state_q == ST_IDLE) && start_i;
  assign ctl_o.access  = (state_q == ST_ACCESS);
  assign ctl_o.exec    = (state_q == ST_EXEC);
  assign ctl_o.scan    = (state_q == ST_SCAN);

endmodule

`default_nettype wire

// ===== hw/rtl/ptlv_chk.sv =====
// Port-level checker for the page table block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module ptlv_chk import ptlv_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      done_i,
  input wire ptlv_rsp_t rsp_i
);

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("Block not busy after an accepted request.");

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> (!busy && $past(busy)))
    else $error("Result strobe without a preceding busy period.");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |=> !done_i)
    else $error("Result strobe held for more than one cycle.");

  a_permit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && rsp_i.permitted) |-> (rsp_i.flags_out[FLAG_VALID_BIT] && !rsp_i.status))
    else $error("Permission granted for an invalid or rejected entry.");

  a_victim_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && (rsp_i.victim != 4'd0)) |->
      ((rsp_i.frame_out == 8'd0) && !rsp_i.permitted && !rsp_i.status))
    else $error("Victim result carries lookup fields.");

endmodule

bind page_table_lru_victim_top ptlv_chk u_ptlv_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_i (done_o),
  .rsp_i  (rsp_o)
);

`default_nettype wire
